// ----- rtl/core/cbf_pkg.sv -----
// Shared constants and controller/datapath interface types for the Bezier flattener.
package cbf_pkg;

  localparam int COORD_W      = 32;
  localparam int SEGMENTS_DEF = 20;
  localparam int CTRL_PTS     = 4;
  localparam int AXIS_STAGES  = 8;

  typedef logic signed [COORD_W-1:0] coord_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture command operands, update current point
    logic issue;  // start one curve sample at the current k
  } cbf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic s1_busy;  // coefficient stage still holds a sample
    logic adv;      // pipeline advances this cycle
  } cbf_stat_t;

endpackage

// ----- rtl/core/cbf_ctrl.sv -----
// Command controller: takes transactions and issues one curve sample per cycle while the pipeline advances.
module cbf_ctrl #(
  parameter int SEGMENTS = cbf_pkg::SEGMENTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  cbf_pkg::cbf_stat_t              stat_i,
  output cbf_pkg::cbf_cmd_t               cmd_o,
  output logic [$clog2(SEGMENTS+1)-1:0]   k_o
);

  localparam int KW = $clog2(SEGMENTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ISSUE = 2'b10
  } cbf_state_e;

  cbf_state_e      state_q, state_d;
  logic [KW-1:0]   k_q, k_d;
  logic            accept;

  assign in_stall_o = !((state_q == ST_IDLE) && !stat_i.s1_busy);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.load  = accept;
  assign cmd_o.issue = (state_q == ST_ISSUE) && stat_i.adv;
  assign k_o         = k_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_ISSUE;
          k_d     = opcode_i ? KW'(1) : KW'(SEGMENTS);
        end
      end
      ST_ISSUE: begin
        if (stat_i.adv) begin
          if (k_q == KW'(SEGMENTS)) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

// ----- rtl/core/cbf_axis.sv -----
// One coordinate of the curve: weighted sum, rounding division by 2*S^3, saturation.
module cbf_axis #(
  parameter int SEGMENTS = cbf_pkg::SEGMENTS_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              en_i,
  input  logic [$clog2(SEGMENTS*SEGMENTS*SEGMENTS+1)-1:0]   coef_i [cbf_pkg::CTRL_PTS],
  input  cbf_pkg::coord_t                                   pt_i [cbf_pkg::CTRL_PTS],
  output cbf_pkg::coord_t                                   res_o
);

  localparam int unsigned DI = SEGMENTS * SEGMENTS * SEGMENTS;
  localparam int unsigned CI = 2 * DI;
  localparam int CW = $clog2(DI + 1);
  localparam int CB = $clog2(CI);
  localparam int PW = CW + cbf_pkg::COORD_W + 1;
  localparam int XW = CB + cbf_pkg::COORD_W + 1;
  localparam int SW = XW + 2;
  localparam int RW = cbf_pkg::COORD_W + 2;
  localparam int QW = cbf_pkg::COORD_W + 1;
  localparam int XL = XW / 2;
  localparam int XH = XW - XL;
  localparam int RL = RW / 2;
  localparam int RH = RW - RL;
  localparam int TW = XW + RW;

  localparam longint unsigned RI = (64'd1 << XW) / 64'(CI);
  localparam logic [RW-1:0]        RK   = RW'(RI);
  localparam logic [RL-1:0]        RK_L = RK[RL-1:0];
  localparam logic [RH-1:0]        RK_H = RK[RW-1:RL];
  localparam logic [XW-1:0]        CK   = XW'(CI);
  // rounding half plus an offset that keeps the dividend positive
  localparam logic signed [SW-1:0] BIAS = SW'(DI) + (SW'(CI) << cbf_pkg::COORD_W);
  localparam logic [QW+1:0]        OFS  = (QW+2)'(64'd1 << cbf_pkg::COORD_W);
  localparam cbf_pkg::coord_t      CMAX = {1'b0, {(cbf_pkg::COORD_W-1){1'b1}}};
  localparam cbf_pkg::coord_t      CMIN = {1'b1, {(cbf_pkg::COORD_W-1){1'b0}}};

  logic signed [PW-1:0] pr_q [cbf_pkg::CTRL_PTS];
  logic signed [PW-1:0] pr_d [cbf_pkg::CTRL_PTS];
  logic signed [SW-1:0] sa_q, sa_d, sb_q, sb_d;
  logic signed [SW-1:0] sum4;
  logic [XW-1:0]        xo4_q, xo4_d, xo5_q, xo6_q, xo7_q, xo8_q;
  logic [XL+RL-1:0]     pp_ll_q, pp_ll_d;
  logic [XL+RH-1:0]     pp_lh_q, pp_lh_d;
  logic [XH+RL-1:0]     pp_hl_q, pp_hl_d;
  logic [XH+RH-1:0]     pp_hh_q, pp_hh_d;
  logic [TW-1:0]        s1_q, s1_d, s2_q, s2_d, tot;
  logic [QW-1:0]        q07_q, q07_d, q08_q;
  logic [XW-1:0]        m8_q, m8_d, rem;
  logic [QW-1:0]        qc_q, qc_d;
  logic signed [QW+1:0] sv;

  always_comb begin
    for (int i = 0; i < cbf_pkg::CTRL_PTS; i++) begin
      pr_d[i] = $signed({1'b0, coef_i[i]}) * pt_i[i];
    end
    sa_d    = SW'(pr_q[0]) + SW'(pr_q[1]);
    sb_d    = SW'(pr_q[2]) + SW'(pr_q[3]);
    sum4    = ((sa_q + sb_q) <<< 1) + BIAS;
    xo4_d   = sum4[XW-1:0];
    pp_ll_d = xo4_q[XL-1:0] * RK_L;
    pp_lh_d = xo4_q[XL-1:0] * RK_H;
    pp_hl_d = xo4_q[XW-1:XL] * RK_L;
    pp_hh_d = xo4_q[XW-1:XL] * RK_H;
    s1_d    = (TW'(pp_hh_q) << (XL + RL)) + (TW'(pp_hl_q) << XL);
    s2_d    = (TW'(pp_lh_q) << RL) + TW'(pp_ll_q);
    tot     = s1_q + s2_q;
    q07_d   = tot[XW+QW-1:XW];
    m8_d    = XW'(q07_q) * CK;
    rem     = xo8_q - m8_q;
    qc_d    = q08_q + QW'(rem >= CK);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < cbf_pkg::CTRL_PTS; i++) begin
        pr_q[i] <= pr_d[i];
      end
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      xo4_q   <= xo4_d;
      pp_ll_q <= pp_ll_d;
      pp_lh_q <= pp_lh_d;
      pp_hl_q <= pp_hl_d;
      pp_hh_q <= pp_hh_d;
      xo5_q   <= xo4_q;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      xo6_q   <= xo5_q;
      q07_q   <= q07_d;
      xo7_q   <= xo6_q;
      m8_q    <= m8_d;
      q08_q   <= q07_q;
      xo8_q   <= xo7_q;
      qc_q    <= qc_d;
    end
  end

  always_comb begin
    sv = $signed({2'b00, qc_q} - OFS);
    if ((sv[QW+1:cbf_pkg::COORD_W-1] == '0) || (sv[QW+1:cbf_pkg::COORD_W-1] == '1)) begin
      res_o = sv[cbf_pkg::COORD_W-1:0];
    end else begin
      res_o = sv[QW+1] ? CMIN : CMAX;
    end
  end

endmodule

// ----- rtl/core/cbf_datapath.sv -----
// Datapath: control point registers, coefficient stage, two axis pipelines, output register.
module cbf_datapath #(
  parameter int SEGMENTS = cbf_pkg::SEGMENTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cbf_pkg::cbf_cmd_t               cmd_i,
  input  logic [$clog2(SEGMENTS+1)-1:0]   k_i,
  output cbf_pkg::cbf_stat_t              stat_o,
  input  logic                            opcode_i,
  input  cbf_pkg::coord_t                 x1_i,
  input  cbf_pkg::coord_t                 y1_i,
  input  cbf_pkg::coord_t                 x2_i,
  input  cbf_pkg::coord_t                 y2_i,
  input  cbf_pkg::coord_t                 x3_i,
  input  cbf_pkg::coord_t                 y3_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cbf_pkg::coord_t                 point_x_o,
  output cbf_pkg::coord_t                 point_y_o,
  output logic                            last_point_o
);

  localparam int KW  = $clog2(SEGMENTS + 1);
  localparam int CW  = $clog2(SEGMENTS * SEGMENTS * SEGMENTS + 1);
  localparam int NST = cbf_pkg::AXIS_STAGES + 1;

  logic [CW-1:0]   tab0 [SEGMENTS+1];
  logic [CW-1:0]   tab1 [SEGMENTS+1];
  logic [CW-1:0]   tab2 [SEGMENTS+1];
  logic [CW-1:0]   tab3 [SEGMENTS+1];
  logic [CW-1:0]   c_q [cbf_pkg::CTRL_PTS];
  cbf_pkg::coord_t px_q [cbf_pkg::CTRL_PTS];
  cbf_pkg::coord_t py_q [cbf_pkg::CTRL_PTS];
  cbf_pkg::coord_t cur_x_q, cur_y_q, end_x, end_y;
  cbf_pkg::coord_t res_x, res_y;
  logic [NST-1:0]  vld_q, lst_q;
  logic            en;
  logic            out_vld_q, out_lst_q;
  cbf_pkg::coord_t out_x_q, out_y_q;

  // Bernstein weights scaled by S^3: u^3, 3u^2k, 3uk^2, k^3
  for (genvar g = 0; g <= SEGMENTS; g++) begin : g_tab
    localparam int unsigned KK = g;
    localparam int unsigned UU = SEGMENTS - g;
    assign tab0[g] = CW'(UU * UU * UU);
    assign tab1[g] = CW'(3 * UU * UU * KK);
    assign tab2[g] = CW'(3 * UU * KK * KK);
    assign tab3[g] = CW'(KK * KK * KK);
  end

  assign en             = !out_vld_q || !out_stall_i;
  assign stat_o.s1_busy = vld_q[0];
  assign stat_o.adv     = en;

  // a point command runs as k = S with the point as the end point
  assign end_x = opcode_i ? x3_i : x1_i;
  assign end_y = opcode_i ? y3_i : y1_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
    end else if (cmd_i.load) begin
      cur_x_q <= end_x;
      cur_y_q <= end_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q[0] <= cur_x_q;
      py_q[0] <= cur_y_q;
      px_q[1] <= x1_i;
      py_q[1] <= y1_i;
      px_q[2] <= x2_i;
      py_q[2] <= y2_i;
      px_q[3] <= end_x;
      py_q[3] <= end_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q[0] <= tab0[k_i];
      c_q[1] <= tab1[k_i];
      c_q[2] <= tab2[k_i];
      c_q[3] <= tab3[k_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      lst_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NST-2:0], cmd_i.issue};
      lst_q     <= {lst_q[NST-2:0], (k_i == KW'(SEGMENTS))};
      out_vld_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q   <= res_x;
      out_y_q   <= res_y;
      out_lst_q <= lst_q[NST-1];
    end
  end

  cbf_axis #(.SEGMENTS(SEGMENTS)) u_axis_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .coef_i (c_q),
    .pt_i   (px_q),
    .res_o  (res_x)
  );

  cbf_axis #(.SEGMENTS(SEGMENTS)) u_axis_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .coef_i (c_q),
    .pt_i   (py_q),
    .res_o  (res_y)
  );

  assign out_valid_o  = out_vld_q;
  assign point_x_o    = out_x_q;
  assign point_y_o    = out_y_q;
  assign last_point_o = out_lst_q;

endmodule

// ----- rtl/core/cubic_bezier_flattener.sv -----
// Top level of the cubic Bezier path flattener.
// A point transaction emits its point (last_point set) and makes it the current point; a cubic
// transaction emits SEGMENTS curve points from the current point to (x3, y3), one per cycle
// while the output is not stalled, the last one flagged, and (x3, y3) becomes current.
// Coordinates are signed Q16.16, rounded to nearest (ties up) and saturated. The controller
// issues one curve sample per cycle, while the pipeline advances, into a ten-stage arithmetic
// pipeline (coefficient lookup, weighted sum, reciprocal division by 2*S^3 in partial
// products, correction, output register); a new transaction is taken only in the idle state
// once the coefficient stage has drained, so the input stays stalled until the last sample of
// the previous one has left it. A stall on a valid output freezes the whole pipeline.
module cubic_bezier_flattener #(
  parameter int SEGMENTS = cbf_pkg::SEGMENTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            opcode_i,
  input  cbf_pkg::coord_t x1_i,
  input  cbf_pkg::coord_t y1_i,
  input  cbf_pkg::coord_t x2_i,
  input  cbf_pkg::coord_t y2_i,
  input  cbf_pkg::coord_t x3_i,
  input  cbf_pkg::coord_t y3_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cbf_pkg::coord_t point_x_o,
  output cbf_pkg::coord_t point_y_o,
  output logic            last_point_o
);

  cbf_pkg::cbf_cmd_t                 cmd;
  cbf_pkg::cbf_stat_t                stat;
  logic [$clog2(SEGMENTS+1)-1:0]     k;

  cbf_ctrl #(.SEGMENTS(SEGMENTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .k_o        (k)
  );

  cbf_datapath #(.SEGMENTS(SEGMENTS)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .k_i          (k),
    .stat_o       (stat),
    .opcode_i     (opcode_i),
    .x1_i         (x1_i),
    .y1_i         (y1_i),
    .x2_i         (x2_i),
    .y2_i         (y2_i),
    .x3_i         (x3_i),
    .y3_i         (y3_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .last_point_o (last_point_o)
  );

endmodule

// ----- sim/cbf_tb_pkg.sv -----
// Command codes shared by the flattener testbench stimulus and its checker.
package cbf_tb_pkg;

  typedef enum logic {
    OP_POINT = 1'b0,
    OP_CUBIC = 1'b1
  } path_op_e;

endpackage

// ----- sim/cubic_bezier_flattener_checker.sv -----
// Checker for the cubic Bezier flattener: predicts each emitted point and scores the output.
module cubic_bezier_flattener_checker #(
  parameter int SEGMENTS = cbf_pkg::SEGMENTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic            opcode_i,
  input  cbf_pkg::coord_t x1_i,
  input  cbf_pkg::coord_t y1_i,
  input  cbf_pkg::coord_t x2_i,
  input  cbf_pkg::coord_t y2_i,
  input  cbf_pkg::coord_t x3_i,
  input  cbf_pkg::coord_t y3_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  cbf_pkg::coord_t point_x_i,
  input  cbf_pkg::coord_t point_y_i,
  input  logic            last_point_i,
  output int              errors_o,
  output int              pending_o
);

  typedef cbf_pkg::coord_t coord_t;

  localparam longint COORD_MAX   = 64'sd2147483647;
  localparam longint COORD_MIN   = -64'sd2147483648;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } path_point_t;

  path_point_t expected_points[$];
  path_point_t want;
  coord_t      cur_x;
  coord_t      cur_y;

  // Exact weighted sum over S^3, rounded half up, clamped.
  function automatic coord_t curve_coord(coord_t p0, coord_t p1, coord_t p2, coord_t p3, int k);
    longint u;
    longint n;
    longint num;
    longint den;
    longint q;
    u   = SEGMENTS - k;
    n   = u * u * u * longint'(p0) + 3 * u * u * k * longint'(p1)
        + 3 * u * k * k * longint'(p2) + longint'(k) * k * k * longint'(p3);
    den = 2 * longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
    num = 2 * n + den / 2;
    q   = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    if (q > COORD_MAX) q = COORD_MAX;
    else if (q < COORD_MIN) q = COORD_MIN;
    return coord_t'(q);
  endfunction

  task automatic predict_points();
    path_point_t pt;
    if (opcode_i == cbf_tb_pkg::OP_POINT) begin
      pt.x = x1_i;
      pt.y = y1_i;
      pt.last = 1'b1;
      expected_points = {expected_points, pt};
      cur_x = x1_i;
      cur_y = y1_i;
    end else begin
      for (int k = 1; k <= SEGMENTS; k++) begin
        pt.x = curve_coord(cur_x, x1_i, x2_i, x3_i, k);
        pt.y = curve_coord(cur_y, y1_i, y2_i, y3_i, k);
        pt.last = (k == SEGMENTS);
        expected_points = {expected_points, pt};
      end
      cur_x = x3_i;
      cur_y = y3_i;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_points.delete();
      cur_x = '0;
      cur_y = '0;
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_points();
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected point, expected none, actual x=%0d y=%0d last=%0b",
                   $time, $signed(point_x_i), $signed(point_y_i), last_point_i);
        end else begin
          want = expected_points.pop_front();
          if (want.x !== point_x_i || want.y !== point_y_i || want.last !== last_point_i) begin
            errors_o++;
            $display({"%0t: point mismatch, expected x=%0d y=%0d last=%0b, ",
                      "actual x=%0d y=%0d last=%0b"},
                     $time, $signed(want.x), $signed(want.y), want.last,
                     $signed(point_x_i), $signed(point_y_i), last_point_i);
          end
        end
      end
      pending_o <= expected_points.size();
    end
  end

endmodule

// ----- sim/cubic_bezier_flattener_tb.sv -----
// Testbench top for the cubic Bezier flattener: drives paths, paces both sides, gives the verdict.
module cubic_bezier_flattener_tb;

  typedef cbf_pkg::coord_t coord_t;

  localparam int SEGS        = cbf_pkg::SEGMENTS_DEF;
  localparam int RAND_ITEMS  = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 30;

  localparam coord_t C_MAX  = 32'h7fffffff;
  localparam coord_t C_MIN  = 32'h80000000;
  localparam coord_t C_ZERO = 32'h00000000;
  localparam coord_t C_NEG1 = 32'hffffffff;
  localparam coord_t C_ONE  = 32'h00000001;
  localparam coord_t Q_ONE  = 32'h00010000;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   opcode_i    = 1'b0;
  coord_t x1_i        = '0;
  coord_t y1_i        = '0;
  coord_t x2_i        = '0;
  coord_t y2_i        = '0;
  coord_t x3_i        = '0;
  coord_t y3_i        = '0;
  logic   out_stall_i = 1'b0;

  logic   in_stall_o;
  logic   out_valid_o;
  coord_t point_x_o;
  coord_t point_y_o;
  logic   last_point_o;

  int   errors;
  int   pending;
  int   in_idle_pct  = 0;
  int   out_idle_pct = 0;
  logic pressure     = 1'b0;

  cubic_bezier_flattener #(.SEGMENTS(SEGS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i,
    .x1_i, .y1_i, .x2_i, .y2_i, .x3_i, .y3_i,
    .out_valid_o, .out_stall_i, .point_x_o, .point_y_o, .last_point_o
  );

  cubic_bezier_flattener_checker #(.SEGMENTS(SEGS)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i,
    .x1_i, .y1_i, .x2_i, .y2_i, .x3_i, .y3_i,
    .out_valid_i(out_valid_o), .out_stall_i, .point_x_i(point_x_o),
    .point_y_i(point_y_o), .last_point_i(last_point_o),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(12 * 1000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side; holds off once for a long stretch when pressure is on.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(2048)) - 1024;
      2: begin
        case ($urandom_range(4))
          0: return C_MAX;
          1: return C_MIN;
          2: return C_ZERO;
          3: return C_NEG1;
          default: return C_ONE;
        endcase
      end
      default: return coord_t'($urandom_range(1 << 21)) - (1 << 20);
    endcase
  endfunction

  task automatic send_cmd(input cbf_tb_pkg::path_op_e op,
                          input coord_t ax1, ay1, ax2, ay2, ax3, ay3);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    x1_i       <= ax1;
    y1_i       <= ay1;
    x2_i       <= ax2;
    y2_i       <= ay2;
    x3_i       <= ax3;
    y3_i       <= ay3;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random(input int count);
    repeat (count)
      send_cmd(($urandom_range(99) < 60) ? cbf_tb_pkg::OP_CUBIC : cbf_tb_pkg::OP_POINT,
               rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord());
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle_pct = 9;
    out_idle_pct <= 74;

    // point operands beyond x1/y1 carry junk
    send_cmd(cbf_tb_pkg::OP_POINT, C_ZERO, C_ZERO, coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), coord_t'($urandom));
    // half-way ties at k = S/2: +0.5 rounds up, -0.5 rounds to zero
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 32'sd4, -32'sd4);
    send_cmd(cbf_tb_pkg::OP_POINT, C_ZERO, C_ZERO, C_NEG1, C_NEG1, C_NEG1, C_NEG1);
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_ONE, C_NEG1, C_NEG1, C_ONE, C_ONE, C_NEG1);
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_NEG1, C_ONE, C_ONE, C_NEG1, C_NEG1, C_ONE);
    send_cmd(cbf_tb_pkg::OP_POINT, C_MAX, C_MIN, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN);
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_cmd(cbf_tb_pkg::OP_POINT, C_MIN, C_MAX, C_NEG1, C_NEG1, C_NEG1, C_NEG1);
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_MIN, C_MIN, C_MAX, C_MAX, C_ZERO, C_ZERO);
    send_cmd(cbf_tb_pkg::OP_POINT, C_NEG1, C_NEG1, C_MAX, C_MIN, C_MAX, C_MIN);
    send_cmd(cbf_tb_pkg::OP_CUBIC, Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    send_cmd(cbf_tb_pkg::OP_CUBIC, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
    send_cmd(cbf_tb_pkg::OP_CUBIC, 32'sd3, -32'sd7, 32'sd11, -32'sd13, 32'sd17, -32'sd19);
    send_cmd(cbf_tb_pkg::OP_POINT, C_ONE, C_ONE, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
    send_random(RAND_ITEMS);
    wait_drained();

    in_idle_pct = 74;
    out_idle_pct <= 9;
    send_random(RAND_ITEMS);
    wait_drained();

    in_idle_pct = 0;
    out_idle_pct <= 0;
    pressure <= 1'b1;
    send_random(RAND_ITEMS);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cbf_pkg.sv
rtl/core/cbf_ctrl.sv
rtl/core/cbf_axis.sv
rtl/core/cbf_datapath.sv
rtl/core/cubic_bezier_flattener.sv
sim/cbf_tb_pkg.sv
sim/cubic_bezier_flattener_checker.sv
sim/cubic_bezier_flattener_tb.sv
